### rtl/csi_pkg.sv
package csi_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] ChEsc     = 8'h1B;
  localparam logic [ByteW-1:0] ChBracket = 8'h5B;  // '['
  localparam logic [ByteW-1:0] ChSemi    = 8'h3B;  // ';'
  localparam logic [ByteW-1:0] ChDigit0  = 8'h30;  // '0'
  localparam logic [ByteW-1:0] ChDigit9  = 8'h39;  // '9'
  localparam logic [ByteW-1:0] ChUpA     = 8'h41;  // 'A'
  localparam logic [ByteW-1:0] ChUpK     = 8'h4B;  // 'K'
  localparam logic [ByteW-1:0] ChUpM     = 8'h4D;  // 'M'
  localparam logic [ByteW-1:0] ChUpS     = 8'h53;  // 'S'
  localparam logic [ByteW-1:0] ChUpT     = 8'h54;  // 'T'
  localparam logic [ByteW-1:0] ChLoF     = 8'h66;  // 'f'
  localparam logic [ByteW-1:0] ChLoH     = 8'h68;  // 'h'
  localparam logic [ByteW-1:0] ChLoI     = 8'h69;  // 'i'
  localparam logic [ByteW-1:0] ChLoL     = 8'h6C;  // 'l'
  localparam logic [ByteW-1:0] ChLoM     = 8'h6D;  // 'm'
  localparam logic [ByteW-1:0] ChLoN     = 8'h6E;  // 'n'
  localparam logic [ByteW-1:0] ChLoS     = 8'h73;  // 's'
  localparam logic [ByteW-1:0] ChLoU     = 8'h75;  // 'u'

  // Scanner mode
  typedef enum logic [1:0] {
    MODE_TEXT  = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_PARAM = 2'd2
  } mode_e;

  // Replay sequencer for results that span several cycles
  typedef enum logic [1:0] {
    REP_IDLE    = 2'd0,
    REP_BRACKET = 2'd1,
    REP_PARAM   = 2'd2,
    REP_TAIL    = 2'd3
  } rep_state_e;

  // One result loaded into the output stage
  typedef struct packed {
    logic             vld;
    logic [ByteW-1:0] data;
    logic             data_valid;
    logic             last;
    logic             chunk_end;
  } out_load_t;

  function automatic logic is_param(input logic [ByteW-1:0] b);
    return ((b >= ChDigit0) && (b <= ChDigit9)) || (b == ChSemi);
  endfunction

  function automatic logic is_final(input logic [ByteW-1:0] b);
    logic hit;
    hit = (b >= ChUpA) && (b <= ChUpK);
    case (b)
      ChUpM, ChUpS, ChUpT, ChLoF, ChLoH, ChLoI,
      ChLoL, ChLoM, ChLoN, ChLoS, ChLoU: hit = 1'b1;
      default: ;
    endcase
    return hit;
  endfunction

endpackage

### rtl/csi_in_if.sv
interface csi_in_if;
  import csi_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             chunk_end;

  modport source (output valid, output in_byte, output chunk_end, input ready);
  modport sink (input valid, input in_byte, input chunk_end, output ready);
endinterface

### rtl/csi_out_if.sv
interface csi_out_if;
  import csi_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             out_valid;
  logic             out_last;
  logic             out_chunk_end;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  output out_chunk_end, input ready);
  modport sink (input valid, input out_byte, input out_valid, input out_last,
                input out_chunk_end, output ready);
endinterface

### rtl/csi_escape_stripper_top.sv
// A byte's first result is loaded into the output register at its transfer and shows in the cycle after it.
// Throughput: one input byte per cycle when it yields a single result or an empty marker and the output is taken.
// A rejected sequence replays ESC, '[', its held parameter bytes from the parameter memory and,
// unless it is a held ESC, the ending byte, at one result per cycle while the output is taken.
// Reset (async, active low) clears mode, held count, replay state and output valid;
// the parameter memory is not cleared, entries are read only after they are written.
module csi_escape_stripper_top #(
  parameter int unsigned PARAM_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  csi_in_if.sink           in_i,
  csi_out_if.source        out_o
);
  import csi_pkg::*;

  localparam int unsigned AddrW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(PARAM_DEPTH + 1);

  out_load_t        load;
  logic             slot_free;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [ByteW-1:0] wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [ByteW-1:0] rd_data;
  logic             out_vld_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_valid_q;
  logic             out_last_q;
  logic             out_ce_q;

  assign slot_free = !out_vld_q || out_o.ready;

  csi_scan_ctrl #(
    .Depth (PARAM_DEPTH),
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_byte_i   (in_i.in_byte),
    .chunk_end_i (in_i.chunk_end),
    .slot_free_i (slot_free),
    .load_o      (load),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  csi_param_mem #(
    .Depth (PARAM_DEPTH),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Hold the output transfer until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (slot_free) begin
      out_vld_q <= load.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && load.vld) begin
      out_byte_q  <= load.data;
      out_valid_q <= load.data_valid;
      out_last_q  <= load.last;
      out_ce_q    <= load.chunk_end;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.out_valid     = out_valid_q;
  assign out_o.out_last      = out_last_q;
  assign out_o.out_chunk_end = out_ce_q;
endmodule

### rtl/csi_param_mem.sv
module csi_param_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [csi_pkg::ByteW-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [csi_pkg::ByteW-1:0] rd_data_o
);
  import csi_pkg::*;

  logic [ByteW-1:0] mem [Depth];
  logic [ByteW-1:0] rd_data_q;

  // Write held parameter bytes
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule

### rtl/csi_scan_ctrl.sv
module csi_scan_ctrl #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned CntW  = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [csi_pkg::ByteW-1:0] in_byte_i,
  input  logic                      chunk_end_i,
  input  logic                      slot_free_i,
  output csi_pkg::out_load_t        load_o,
  output logic                      wr_en_o,
  output logic [AddrW-1:0]          wr_addr_o,
  output logic [csi_pkg::ByteW-1:0] wr_data_o,
  output logic                      rd_en_o,
  output logic [AddrW-1:0]          rd_addr_o,
  input  logic [csi_pkg::ByteW-1:0] rd_data_i
);
  import csi_pkg::*;

  mode_e            mode_q, mode_d;
  rep_state_e       rep_q, rep_d, acc_rep;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rep_cnt_q, rep_cnt_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [ByteW-1:0] tail_q, tail_d;
  logic             tail_en_q, tail_en_d;
  logic             ce_q, ce_d;
  logic             accept;
  logic             b_esc_hold;
  logic             par_last;
  logic [CntW-1:0]  idx_next;
  out_load_t        acc_load;
  out_load_t        marker;

  assign in_ready_o = (rep_q == REP_IDLE) && slot_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b_esc_hold = (in_byte_i == ChEsc) && !chunk_end_i;
  assign idx_next   = CntW'(idx_q) + CntW'(1);
  assign par_last   = (idx_next == rep_cnt_q);

  always_comb begin
    marker = '{vld: 1'b1, data: '0, data_valid: 1'b0, last: 1'b1, chunk_end: chunk_end_i};
  end

  // Decode an accepted byte: immediate result, mode update and replay start
  always_comb begin
    acc_load  = marker;
    acc_rep   = REP_IDLE;
    mode_d    = mode_q;
    count_d   = count_q;
    rep_cnt_d = rep_cnt_q;
    tail_d    = tail_q;
    tail_en_d = tail_en_q;
    ce_d      = ce_q;
    wr_en_o   = 1'b0;
    wr_addr_o = AddrW'(count_q);
    wr_data_o = in_byte_i;
    if (accept) begin
      ce_d   = chunk_end_i;
      tail_d = in_byte_i;
      unique case (mode_q)
        MODE_ESC: begin
          if (in_byte_i == ChBracket) begin
            count_d = '0;
            mode_d  = chunk_end_i ? MODE_TEXT : MODE_PARAM;
          end else if (b_esc_hold) begin
            // ESC then ESC: emit the first, hold the second
            acc_load = '{vld: 1'b1, data: ChEsc, data_valid: 1'b1, last: 1'b1,
                         chunk_end: chunk_end_i};
          end else begin
            acc_load = '{vld: 1'b1, data: ChEsc, data_valid: 1'b1, last: 1'b0,
                         chunk_end: 1'b0};
            acc_rep  = REP_TAIL;
            mode_d   = MODE_TEXT;
          end
        end
        MODE_PARAM: begin
          if (is_param(in_byte_i) && chunk_end_i) begin
            // drop the unfinished sequence
            count_d = '0;
            mode_d  = MODE_TEXT;
          end else if (is_param(in_byte_i) && (count_q < CntW'(Depth))) begin
            wr_en_o = 1'b1;
            count_d = count_q + CntW'(1);
          end else if (is_final(in_byte_i) && !is_param(in_byte_i)) begin
            count_d = '0;
            mode_d  = MODE_TEXT;
          end else begin
            // flush ESC, '[', held bytes and maybe this byte as text
            acc_load  = '{vld: 1'b1, data: ChEsc, data_valid: 1'b1, last: 1'b0,
                          chunk_end: 1'b0};
            acc_rep   = REP_BRACKET;
            rep_cnt_d = count_q;
            count_d   = '0;
            if (!is_param(in_byte_i) && b_esc_hold) begin
              tail_en_d = 1'b0;
              mode_d    = MODE_ESC;
            end else begin
              tail_en_d = 1'b1;
              mode_d    = MODE_TEXT;
            end
          end
        end
        default: begin
          mode_d = MODE_TEXT;
          if (b_esc_hold) begin
            mode_d = MODE_ESC;
          end else begin
            acc_load = '{vld: 1'b1, data: in_byte_i, data_valid: 1'b1, last: 1'b1,
                         chunk_end: chunk_end_i};
          end
        end
      endcase
    end
  end

  // Next replay state
  always_comb begin
    rep_d = rep_q;
    unique case (rep_q)
      REP_IDLE: begin
        if (accept) begin
          rep_d = acc_rep;
        end
      end
      REP_BRACKET: begin
        if (slot_free_i) begin
          if (rep_cnt_q != '0) begin
            rep_d = REP_PARAM;
          end else begin
            rep_d = tail_en_q ? REP_TAIL : REP_IDLE;
          end
        end
      end
      REP_PARAM: begin
        if (slot_free_i && par_last) begin
          rep_d = tail_en_q ? REP_TAIL : REP_IDLE;
        end
      end
      REP_TAIL: begin
        if (slot_free_i) begin
          rep_d = REP_IDLE;
        end
      end
      default: rep_d = REP_IDLE;
    endcase
  end

  // Replay outputs and memory reads
  always_comb begin
    load_o    = '{vld: 1'b0, data: '0, data_valid: 1'b0, last: 1'b0, chunk_end: 1'b0};
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    idx_d     = idx_q;
    unique case (rep_q)
      REP_IDLE: begin
        if (accept) begin
          load_o = acc_load;
        end
      end
      REP_BRACKET: begin
        if (slot_free_i) begin
          load_o.vld        = 1'b1;
          load_o.data       = ChBracket;
          load_o.data_valid = 1'b1;
          load_o.last       = (rep_cnt_q == '0) && !tail_en_q;
          load_o.chunk_end  = load_o.last && ce_q;
          // fetch the first held byte
          rd_en_o = (rep_cnt_q != '0);
          idx_d   = '0;
        end
      end
      REP_PARAM: begin
        if (slot_free_i) begin
          load_o.vld        = 1'b1;
          load_o.data       = rd_data_i;
          load_o.data_valid = 1'b1;
          load_o.last       = par_last && !tail_en_q;
          load_o.chunk_end  = load_o.last && ce_q;
          if (!par_last) begin
            rd_en_o   = 1'b1;
            rd_addr_o = AddrW'(idx_next);
            idx_d     = AddrW'(idx_next);
          end
        end
      end
      REP_TAIL: begin
        if (slot_free_i) begin
          load_o = '{vld: 1'b1, data: tail_q, data_valid: 1'b1, last: 1'b1,
                     chunk_end: ce_q};
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_TEXT;
      rep_q   <= REP_IDLE;
      count_q <= '0;
    end else begin
      mode_q  <= mode_d;
      rep_q   <= rep_d;
      count_q <= count_d;
    end
  end

  // Replay context
  always_ff @(posedge clk_i) begin
    rep_cnt_q <= rep_cnt_d;
    idx_q     <= idx_d;
    tail_q    <= tail_d;
    tail_en_q <= tail_en_d;
    ce_q      <= ce_d;
  end
endmodule
